// ----- rtl/sgdpu_pkg.sv -----
package sgdpu_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam int SIG_ENTRIES = 1000;
  localparam int SIG_IDX_W = $clog2(SIG_ENTRIES);
  localparam int SIG_E_W = $clog2(SIG_ENTRIES + 1);
  localparam int SIG_BOUND = 6;
  localparam logic signed [31:0] SIG_BOUND_Q24 = 32'(SIG_BOUND) <<< 24;
  localparam int Y_W = $clog2(2 * SIG_BOUND) + 24;
  localparam int Z_SHIFT = 26;
  localparam int Z_W = $clog2(4 * SIG_ENTRIES);
  localparam int RECIP3 = 21846;
  localparam int RECIP_W = 16;
  localparam logic [16:0] SIG_ONE = 17'h10000;

  localparam int G_W = 33;
  localparam int P_W = G_W + 16;
  localparam int R_W = P_W - 32;
  localparam int SUM_W = R_W + 1;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [16:0] sig_val_t;
  typedef sig_val_t sig_rom_t [SIG_ENTRIES];

  typedef struct packed {
    logic signed [15:0] u_element;
    logic signed [15:0] v_element;
    logic               label;
    logic [15:0]        learn_rate;
    logic               first_of_sample;
    logic               last_element;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] new_v_element;
    logic signed [15:0] error_element;
    logic               last_out;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_SIG_RANGE,
    OP_SIG_INDEX,
    OP_SIG_LOOKUP,
    OP_GRAD,
    OP_READ,
    OP_MUL_U,
    OP_MUL_V,
    OP_WRITE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             store;
    logic [IDX_W-1:0] idx;
    logic             last_out;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // Unsigned quotient by shift and subtract, evaluated only while the table is built.
  function automatic longint unsigned div_u64(
    input longint unsigned n,
    input longint unsigned d
  );
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table in unsigned Q1.16, built once at elaboration.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    longint num;
    longint sum;
    longint unsigned mag;
    longint unsigned b;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      num = longint'(2 * SIG_BOUND * k) - longint'(SIG_BOUND * SIG_ENTRIES);
      mag = (num < 0) ? 64'(-num) : 64'(num);
      b = div_u64(mag << 30, 64'd8 * 64'(SIG_ENTRIES));
      term = ONE_Q30;
      sum = longint'(ONE_Q30);
      for (int i = 1; i <= 24; i++) begin
        term = div_u64(term * b, 64'(i) << 30);
        if (i[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = 64'(sum);
      for (int j = 0; j < 3; j++) begin
        e = (e * e + (ONE_Q30 >> 1)) >> 30;
      end
      den = ONE_Q30 + e;
      if (num >= 0) begin
        q = div_u64((64'd1 << 46) + (den >> 1), den);
      end else begin
        q = div_u64((e << 16) + (den >> 1), den);
      end
      rom[k] = q[16:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ----- rtl/sgdpu_ctrl.sv -----
module sgdpu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  sgdpu_pkg::status_t status_i,
  output sgdpu_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_SIG_RANGE,
    S_SIG_INDEX,
    S_SIG_LOOKUP,
    S_GRAD,
    S_READ,
    S_MUL_U,
    S_MUL_V,
    S_WRITE
  } state_e;

  state_e                      state_q;
  logic [sgdpu_pkg::CNT_W-1:0] cnt_q;
  logic [sgdpu_pkg::CNT_W-1:0] pos_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        in_room;
  logic                        run_end;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_room     = cnt_q < sgdpu_pkg::CNT_W'(sgdpu_pkg::MAX_LEN);
  assign run_end     = (pos_q + sgdpu_pkg::CNT_W'(1)) == cnt_q;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op       = sgdpu_pkg::OP_NONE;
    cmd_o.store    = 1'b0;
    cmd_o.idx      = '0;
    cmd_o.last_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = sgdpu_pkg::OP_LOAD;
        end
      end
      S_ACC: begin
        cmd_o.op    = sgdpu_pkg::OP_ACC;
        cmd_o.store = in_room;
        cmd_o.idx   = cnt_q[sgdpu_pkg::IDX_W-1:0];
      end
      S_SIG_RANGE:  cmd_o.op = sgdpu_pkg::OP_SIG_RANGE;
      S_SIG_INDEX:  cmd_o.op = sgdpu_pkg::OP_SIG_INDEX;
      S_SIG_LOOKUP: cmd_o.op = sgdpu_pkg::OP_SIG_LOOKUP;
      S_GRAD:       cmd_o.op = sgdpu_pkg::OP_GRAD;
      S_READ: begin
        cmd_o.op  = sgdpu_pkg::OP_READ;
        cmd_o.idx = pos_q[sgdpu_pkg::IDX_W-1:0];
      end
      S_MUL_U: cmd_o.op = sgdpu_pkg::OP_MUL_U;
      S_MUL_V: cmd_o.op = sgdpu_pkg::OP_MUL_V;
      S_WRITE: begin
        if (out_free) begin
          cmd_o.op       = sgdpu_pkg::OP_WRITE;
          cmd_o.idx      = pos_q[sgdpu_pkg::IDX_W-1:0];
          cmd_o.last_out = run_end;
        end
      end
      default: cmd_o.op = sgdpu_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (in_room) begin
            cnt_q <= cnt_q + sgdpu_pkg::CNT_W'(1);
          end
          pos_q   <= '0;
          state_q <= status_i.last ? S_SIG_RANGE : S_IDLE;
        end
        S_SIG_RANGE:  state_q <= S_SIG_INDEX;
        S_SIG_INDEX:  state_q <= S_SIG_LOOKUP;
        S_SIG_LOOKUP: state_q <= S_GRAD;
        S_GRAD:       state_q <= S_READ;
        S_READ:       state_q <= S_MUL_U;
        S_MUL_U:      state_q <= S_MUL_V;
        S_MUL_V:      state_q <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            if (run_end) begin
              cnt_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              pos_q   <= pos_q + sgdpu_pkg::CNT_W'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sgdpu_dp.sv -----
module sgdpu_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sgdpu_pkg::cmd_t      cmd_i,
  input  sgdpu_pkg::in_word_t  in_data_i,
  output sgdpu_pkg::status_t   status_o,
  output sgdpu_pkg::out_word_t out_data_o
);

  function automatic logic signed [sgdpu_pkg::R_W-1:0] round_q12(
    input logic signed [sgdpu_pkg::P_W-1:0] p
  );
    logic [sgdpu_pkg::P_W-1:0] t;
    t = p + (sgdpu_pkg::P_W'(1) << 31);
    return t[sgdpu_pkg::P_W-1:32];
  endfunction

  function automatic logic signed [15:0] sat16(
    input logic signed [sgdpu_pkg::SUM_W-1:0] x
  );
    if (x[sgdpu_pkg::SUM_W-1:15] == '0 || x[sgdpu_pkg::SUM_W-1:15] == '1) begin
      return x[15:0];
    end
    return x[sgdpu_pkg::SUM_W-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  logic signed [15:0] src_mem [sgdpu_pkg::MAX_LEN];
  logic signed [15:0] tgt_mem [sgdpu_pkg::MAX_LEN];
  logic signed [15:0] err_mem [sgdpu_pkg::MAX_LEN];
  logic [sgdpu_pkg::MAX_LEN-1:0] err_vld_q;

  logic signed [15:0]              u_q;
  logic signed [15:0]              v_q;
  logic                            label_q;
  logic [15:0]                     rate_q;
  logic                            first_q;
  logic                            last_q;
  logic signed [31:0]              prod_q;
  logic signed [31:0]              dot_q;
  logic                            hi_q;
  logic                            lo_q;
  logic [sgdpu_pkg::Z_W-1:0]       z_q;
  logic [sgdpu_pkg::SIG_IDX_W-1:0] k_q;
  logic [16:0]                     s_q;
  logic signed [sgdpu_pkg::G_W-1:0] g_q;
  logic signed [15:0]              su_q;
  logic signed [15:0]              tv_q;
  logic signed [15:0]              er_q;
  logic                            ev_q;
  logic signed [sgdpu_pkg::P_W-1:0] p_q;
  logic signed [15:0]              nv_q;
  sgdpu_pkg::out_word_t            out_q;

  logic [32:0]                                 dot_sum;
  logic signed [32:0]                          y;
  logic [sgdpu_pkg::Y_W+sgdpu_pkg::SIG_E_W-1:0] yz;
  logic [sgdpu_pkg::Z_W+sgdpu_pkg::RECIP_W-1:0] kp;
  logic [sgdpu_pkg::Z_W-1:0]                   k_full;
  logic signed [17:0]                          diff;
  logic signed [34:0]                          g_full;
  logic signed [15:0]                          mul_b;
  logic signed [sgdpu_pkg::R_W-1:0]            rnd;
  logic signed [sgdpu_pkg::SUM_W-1:0]          nv_sum;
  logic signed [15:0]                          er_eff;
  logic signed [sgdpu_pkg::SUM_W-1:0]          ne_sum;
  logic signed [15:0]                          ne;
  logic                                        tgt_we;
  logic signed [15:0]                          tgt_wd;

  assign dot_sum = {dot_q[31], dot_q} + {prod_q[31], prod_q};
  assign y       = {dot_q[31], dot_q} + {sgdpu_pkg::SIG_BOUND_Q24[31], sgdpu_pkg::SIG_BOUND_Q24};
  assign yz      = y[sgdpu_pkg::Y_W-1:0] * sgdpu_pkg::SIG_E_W'(sgdpu_pkg::SIG_ENTRIES);
  assign kp      = z_q * sgdpu_pkg::RECIP_W'(sgdpu_pkg::RECIP3);
  assign k_full  = kp[sgdpu_pkg::RECIP_W +: sgdpu_pkg::Z_W];
  assign diff    = $signed({1'b0, label_q, 16'h0000}) - $signed({1'b0, s_q});
  assign g_full  = diff * $signed({1'b0, rate_q});
  assign mul_b   = (cmd_i.op == sgdpu_pkg::OP_MUL_V) ? tv_q : su_q;
  assign rnd     = round_q12(p_q);
  assign nv_sum  = {{(sgdpu_pkg::SUM_W-16){tv_q[15]}}, tv_q} + {rnd[sgdpu_pkg::R_W-1], rnd};
  assign er_eff  = ev_q ? er_q : 16'sd0;
  assign ne_sum  = {{(sgdpu_pkg::SUM_W-16){er_eff[15]}}, er_eff} + {rnd[sgdpu_pkg::R_W-1], rnd};
  assign ne      = sat16(ne_sum);
  assign tgt_we  = (cmd_i.op == sgdpu_pkg::OP_ACC && cmd_i.store) ||
                   cmd_i.op == sgdpu_pkg::OP_WRITE;
  assign tgt_wd  = (cmd_i.op == sgdpu_pkg::OP_WRITE) ? nv_q : v_q;

  assign status_o.last  = last_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sgdpu_pkg::OP_ACC && cmd_i.store) begin
      src_mem[cmd_i.idx] <= u_q;
    end
    if (tgt_we) begin
      tgt_mem[cmd_i.idx] <= tgt_wd;
    end
    if (cmd_i.op == sgdpu_pkg::OP_WRITE) begin
      err_mem[cmd_i.idx] <= ne;
    end
    if (cmd_i.op == sgdpu_pkg::OP_READ) begin
      su_q <= src_mem[cmd_i.idx];
      tv_q <= tgt_mem[cmd_i.idx];
      er_q <= err_mem[cmd_i.idx];
      ev_q <= err_vld_q[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q     <= '0;
      err_vld_q <= '0;
      last_q    <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      case (cmd_i.op)
        sgdpu_pkg::OP_LOAD: begin
          first_q <= in_data_i.first_of_sample;
          last_q  <= in_data_i.last_element;
        end
        sgdpu_pkg::OP_ACC: begin
          if (cmd_i.store) begin
            if (dot_sum[32] != dot_sum[31]) begin
              dot_q <= dot_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
              dot_q <= dot_sum[31:0];
            end
          end
          if (first_q) begin
            err_vld_q <= '0;
          end
        end
        sgdpu_pkg::OP_GRAD: dot_q <= '0;
        sgdpu_pkg::OP_WRITE: err_vld_q[cmd_i.idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sgdpu_pkg::OP_LOAD: begin
        u_q     <= in_data_i.u_element;
        v_q     <= in_data_i.v_element;
        label_q <= in_data_i.label;
        rate_q  <= in_data_i.learn_rate;
        prod_q  <= in_data_i.u_element * in_data_i.v_element;
      end
      sgdpu_pkg::OP_SIG_RANGE: begin
        hi_q <= dot_q > sgdpu_pkg::SIG_BOUND_Q24;
        lo_q <= dot_q < -sgdpu_pkg::SIG_BOUND_Q24;
        z_q  <= yz[sgdpu_pkg::Z_SHIFT +: sgdpu_pkg::Z_W];
      end
      sgdpu_pkg::OP_SIG_INDEX: begin
        if (k_full > sgdpu_pkg::Z_W'(sgdpu_pkg::SIG_ENTRIES - 1)) begin
          k_q <= sgdpu_pkg::SIG_IDX_W'(sgdpu_pkg::SIG_ENTRIES - 1);
        end else begin
          k_q <= k_full[sgdpu_pkg::SIG_IDX_W-1:0];
        end
      end
      sgdpu_pkg::OP_SIG_LOOKUP: begin
        if (hi_q) begin
          s_q <= sgdpu_pkg::SIG_ONE;
        end else if (lo_q) begin
          s_q <= '0;
        end else begin
          s_q <= sgdpu_pkg::SIG_ROM[k_q];
        end
      end
      sgdpu_pkg::OP_GRAD: g_q <= g_full[sgdpu_pkg::G_W-1:0];
      sgdpu_pkg::OP_MUL_U: p_q <= g_q * mul_b;
      sgdpu_pkg::OP_MUL_V: begin
        nv_q <= sat16(nv_sum);
        p_q  <= g_q * mul_b;
      end
      sgdpu_pkg::OP_WRITE: begin
        out_q.new_v_element <= nv_q;
        out_q.error_element <= ne;
        out_q.last_out      <= cmd_i.last_out;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/embedding_sgd_pair_update_top.sv -----
// Embedding pair update for skip-gram training with negative sampling.
// The input channel carries one word per vector element: the source and
// target elements in Q4.12, the label, the learning rate, and the flags that
// open a sample and close a vector pair. The output channel carries one word
// per buffered element once a pair closes: the updated target element, the
// running error for that element, and a flag on the final word of the run.
// Loading latches each input word and forms its product, then buffers it and
// adds the product into the dot product; the input channel stalls meanwhile.
// The word that closes a pair then passes the sigmoid range check, index and
// lookup, and the gradient. Each result is then read, multiplied by the
// gradient with the source and then the target element, and written, in turn,
// set by the single read port of the element buffers and the shared update
// multiplier. The input channel stalls while a run is in progress. When the
// receiver stalls, the finished word waits in the output register and the
// next result waits until it is taken; the block accepts new input words
// while the last word of a run is still waiting. Reset clears the dot
// product, the element count and the error valid flags; the element buffers
// need no clearing since only entries written in the current pair are read.
module embedding_sgd_pair_update_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sgdpu_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sgdpu_pkg::out_word_t out_data_o
);

  sgdpu_pkg::cmd_t    cmd;
  sgdpu_pkg::status_t status;

  sgdpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgdpu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
